[rtl/sct_pkg.sv]
// ============================================================================
// sct_pkg
// Shared types and constants of the shell command tokenizer: payload structs,
// result bundle, character codes, event and token codes.
// ============================================================================
package sct_pkg;

    localparam int SCT_MAX_RESULTS  = 4;
    localparam int SCT_QUEUE_DEPTH  = 4;
    localparam int SCT_CNT_W        = $clog2(SCT_MAX_RESULTS + 1);

    localparam logic [7:0] SCT_MAX_TOKENS_RESET = 8'd255;

    localparam int         SCT_APB_ADDR_W = 3;
    localparam logic       REG_MAX_TOKENS = 1'b0;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_OP   = 2'd2;
    localparam logic [1:0] EV_LINE = 2'd3;

    localparam logic [2:0] TK_WORD   = 3'd0;
    localparam logic [2:0] TK_QUOTED = 3'd1;
    localparam logic [2:0] TK_GT     = 3'd2;
    localparam logic [2:0] TK_GTGT   = 3'd3;
    localparam logic [2:0] TK_LT     = 3'd4;
    localparam logic [2:0] TK_PIPE   = 3'd5;
    localparam logic [2:0] TK_AMP    = 3'd6;
    localparam logic [2:0] TK_NONE   = 3'd0;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_QUOTED  = 5'b00100,
        MODE_GT_HELD = 5'b01000,
        MODE_DROPPED = 5'b10000
    } sct_mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_of_line;
    } sct_in_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [2:0] token_kind;
        logic [7:0] token_byte;
        logic [7:0] token_number;
        logic       last_result;
    } sct_out_t;

    typedef struct packed {
        logic [SCT_CNT_W-1:0]            count;
        sct_out_t [SCT_MAX_RESULTS-1:0]  res;
    } sct_bundle_t;

endpackage

[rtl/sct_queue.sv]
// ============================================================================
// sct_queue
// Small FIFO of result bundles between the lexer front and the output back.
// ============================================================================
module sct_queue #(
    parameter int DEPTH = sct_pkg::SCT_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  sct_pkg::sct_bundle_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sct_pkg::sct_bundle_t pop_data
);
    import sct_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    sct_bundle_t        mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/sct_front.sv]
// ============================================================================
// sct_front
// Lexer front: accepts one byte per cycle while the queue has room, updates
// the lexer state and builds the bundle of results that the byte causes.
// ============================================================================
module sct_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           max_tokens,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sct_pkg::sct_in_t     in_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output sct_pkg::sct_bundle_t push_data
);
    import sct_pkg::*;

    typedef struct packed {
        sct_mode_t   mode;
        logic        qd;
        logic [7:0]  ts;
        sct_bundle_t b;
    } lex_state_t;

    sct_mode_t   mode_reg;
    logic        quote_double_reg;
    logic [7:0]  tokens_reg;
    lex_state_t  st_next;

    function automatic sct_bundle_t emit(sct_bundle_t b, logic [1:0] ev, logic [2:0] tk,
                                         logic [7:0] tbyte, logic [7:0] num);
        if (b.count < SCT_CNT_W'(SCT_MAX_RESULTS)) begin
            b.res[b.count[1:0]].event_kind   = ev;
            b.res[b.count[1:0]].token_kind   = tk;
            b.res[b.count[1:0]].token_byte   = tbyte;
            b.res[b.count[1:0]].token_number = num;
            b.res[b.count[1:0]].last_result  = 1'b0;
            b.count = b.count + 1'b1;
        end
        return b;
    endfunction

    function automatic logic ends_word(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LT) || (c == CH_GT) ||
               (c == CH_PIPE) || (c == CH_AMP) || (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

    function automatic lex_state_t begin_token(lex_state_t st, logic [7:0] c,
                                               logic [7:0] maxt);
        if (c != CH_SPACE && c != CH_TAB) begin
            if (st.ts >= maxt) begin
                st.mode = MODE_DROPPED;
            end else begin
                st.ts = st.ts + 8'd1;
                unique case (c)
                    CH_GT: begin
                        st.mode = MODE_GT_HELD;
                    end
                    CH_LT: begin
                        st.b = emit(st.b, EV_OP, TK_LT, 8'd0, st.ts - 8'd1);
                    end
                    CH_PIPE: begin
                        st.b = emit(st.b, EV_OP, TK_PIPE, 8'd0, st.ts - 8'd1);
                    end
                    CH_AMP: begin
                        st.b = emit(st.b, EV_OP, TK_AMP, 8'd0, st.ts - 8'd1);
                    end
                    CH_DQUOTE, CH_SQUOTE: begin
                        st.mode = MODE_QUOTED;
                        st.qd   = (c == CH_DQUOTE);
                    end
                    default: begin
                        st.mode = MODE_WORD;
                        st.b = emit(st.b, EV_BYTE, TK_WORD, c, st.ts - 8'd1);
                    end
                endcase
            end
        end
        return st;
    endfunction

    function automatic lex_state_t close_open(lex_state_t st);
        if (st.mode == MODE_WORD) begin
            st.b = emit(st.b, EV_END, TK_WORD, 8'd0, st.ts - 8'd1);
        end else if (st.mode == MODE_QUOTED) begin
            st.b = emit(st.b, EV_END, TK_QUOTED, 8'd0, st.ts - 8'd1);
        end else if (st.mode == MODE_GT_HELD) begin
            st.b = emit(st.b, EV_OP, TK_GT, 8'd0, st.ts - 8'd1);
        end
        st.mode = MODE_IDLE;
        return st;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [7:0] q;
        logic [SCT_CNT_W-1:0] last_idx;
        c = in_data.char_code;
        st_next.mode    = mode_reg;
        st_next.qd      = quote_double_reg;
        st_next.ts      = tokens_reg;
        st_next.b       = '0;
        q = quote_double_reg ? CH_DQUOTE : CH_SQUOTE;

        priority if (mode_reg == MODE_DROPPED) begin
            st_next.mode = MODE_DROPPED;
        end else if (c == CH_NUL) begin
            st_next = close_open(st_next);
            st_next.mode = MODE_DROPPED;
        end else if (mode_reg == MODE_GT_HELD) begin
            if (c == CH_GT) begin
                st_next.b = emit(st_next.b, EV_OP, TK_GTGT, 8'd0, st_next.ts - 8'd1);
                st_next.mode = MODE_IDLE;
            end else begin
                st_next.b = emit(st_next.b, EV_OP, TK_GT, 8'd0, st_next.ts - 8'd1);
                st_next.mode = MODE_IDLE;
                st_next = begin_token(st_next, c, max_tokens);
            end
        end else if (mode_reg == MODE_QUOTED) begin
            if (c == q) begin
                st_next.b = emit(st_next.b, EV_END, TK_QUOTED, 8'd0, st_next.ts - 8'd1);
                st_next.mode = MODE_IDLE;
            end else begin
                st_next.b = emit(st_next.b, EV_BYTE, TK_QUOTED, c, st_next.ts - 8'd1);
            end
        end else if (mode_reg == MODE_WORD) begin
            if (ends_word(c)) begin
                st_next.b = emit(st_next.b, EV_END, TK_WORD, 8'd0, st_next.ts - 8'd1);
                st_next.mode = MODE_IDLE;
                st_next = begin_token(st_next, c, max_tokens);
            end else begin
                st_next.b = emit(st_next.b, EV_BYTE, TK_WORD, c, st_next.ts - 8'd1);
            end
        end else begin
            st_next = begin_token(st_next, c, max_tokens);
        end

        if (in_data.last_of_line) begin
            st_next = close_open(st_next);
            st_next.b = emit(st_next.b, EV_LINE, TK_NONE, 8'd0, st_next.ts);
            st_next.mode = MODE_IDLE;
            st_next.qd   = 1'b0;
            st_next.ts   = 8'd0;
        end

        last_idx = st_next.b.count - 1'b1;
        if (st_next.b.count != '0) begin
            st_next.b.res[last_idx[1:0]].last_result = 1'b1;
        end
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid && (st_next.b.count != '0);
    assign push_data  = st_next.b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_IDLE;
            quote_double_reg <= 1'b0;
            tokens_reg       <= 8'd0;
        end else if (in_valid && in_ready) begin
            mode_reg         <= st_next.mode;
            quote_double_reg <= st_next.qd;
            tokens_reg       <= st_next.ts;
        end
    end

endmodule

[rtl/sct_back.sv]
// ============================================================================
// sct_back
// Output back: walks the bundle at the queue head and sends one result per
// transfer through a registered output stage.
// ============================================================================
module sct_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  sct_pkg::sct_bundle_t pop_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sct_pkg::sct_out_t    out_data
);
    import sct_pkg::*;

    localparam int IDX_W = $clog2(SCT_MAX_RESULTS);

    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    sct_out_t              data_reg, data_next;
    logic                  load;
    logic                  at_last;
    logic [SCT_CNT_W-1:0]  last_idx;

    assign load     = !valid_reg || out_ready;
    assign last_idx = pop_data.count - 1'b1;
    assign at_last  = (SCT_CNT_W'(idx_reg) == last_idx);
    assign pop_ready = load && pop_valid && at_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = pop_valid;
            if (pop_valid) begin
                data_next = pop_data.res[idx_reg];
                idx_next  = at_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/shell_command_tokenizer_top.sv]
// ============================================================================
// shell_command_tokenizer_top
// Splits a command line, one byte per transfer, into word, quoted and
// operator tokens with a line-end count.
// ============================================================================
// The block takes one byte per cycle as long as its bundle queue has room;
// the lexer front settles each byte in that same cycle and queues all of its
// results (up to four) as one bundle, if it has any. The output stage sends
// one result per cycle while m_ready is high, so a byte with k results takes
// k transfers of the result channel; QUEUE_DEPTH bundles absorb the bursts.
// max_tokens is written over the APB port at addresses 0 to 3; the user must
// do so only while the block is idle, which the block does not enforce.
module shell_command_tokenizer_top #(
    parameter int QUEUE_DEPTH = sct_pkg::SCT_QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sct_pkg::sct_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sct_pkg::sct_out_t                   m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sct_pkg::SCT_APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import sct_pkg::*;

    logic [7:0]   max_tokens_reg;
    logic         push_valid, push_ready;
    sct_bundle_t  push_data;
    logic         pop_valid, pop_ready;
    sct_bundle_t  pop_data;
    logic         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[SCT_APB_ADDR_W-1] == REG_MAX_TOKENS);
    assign prdata  = reg_sel ? {24'd0, max_tokens_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_tokens_reg <= SCT_MAX_TOKENS_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            max_tokens_reg <= pwdata[7:0];
        end
    end

    sct_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_tokens (max_tokens_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_data    (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sct_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

[rtl/sct_checker.sv]
// ============================================================================
// sct_port_checker
// Port-level checks of the tokenizer, bound to the top level.
// ============================================================================
module sct_port_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input sct_pkg::sct_out_t m_data,
    input logic              pready
);
    import sct_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk)
        aresetn && m_valid && !m_ready ##1 aresetn |-> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_kind == EV_LINE) |->
            m_data.last_result && (m_data.token_kind == TK_NONE) &&
            (m_data.token_byte == 8'd0))
        else $error("malformed line end event");

    a_byte_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_kind == EV_BYTE) |->
            (m_data.token_byte != CH_NUL) &&
            ((m_data.token_kind == TK_WORD) || (m_data.token_kind == TK_QUOTED)))
        else $error("malformed token byte event");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind shell_command_tokenizer_top sct_port_checker u_sct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);
